// ===== rtl/core/ps2mt_pkg.sv =====
// shared types and constants for the ps/2 mouse cursor tracker
package ps2mt_pkg;

  localparam int unsigned CURSOR_MARGIN_DEF = 20;
  localparam int unsigned COORD_W           = 12;
  localparam int unsigned CFG_IDX_W         = 1;

  localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd800;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd600;
  localparam logic [COORD_W-1:0] POS_X_RST  = 12'd400;
  localparam logic [COORD_W-1:0] POS_Y_RST  = 12'd300;

  localparam int unsigned LEFT_BIT = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } byte_phase_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_DRAG    = 3'd2,
    EV_HOVER   = 3'd3,
    EV_NONE    = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_aux;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;
    event_kind_t        event_kind;
    logic               left_down;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
  } screen_cfg_t;

endpackage

// ===== rtl/core/ps2mt_in_reg.sv =====
// input register stage holding one controller byte request
module ps2mt_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ps2mt_pkg::in_item_t in_data,
  output logic                s1_valid,
  output ps2mt_pkg::in_item_t s1_item,
  input  logic                s1_take
);
  import ps2mt_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_item_r;

  assign in_stall = s1_valid_r && !s1_take;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/ps2mt_axis_clamp.sv =====
// one axis: add signed delta and clamp to [0, size - margin]
module ps2mt_axis_clamp #(
  parameter int unsigned CURSOR_MARGIN = ps2mt_pkg::CURSOR_MARGIN_DEF
) (
  input  logic [ps2mt_pkg::COORD_W-1:0] pos,
  input  logic [7:0]                    delta,
  input  logic [ps2mt_pkg::COORD_W-1:0] size,
  output logic [ps2mt_pkg::COORD_W-1:0] pos_new
);
  import ps2mt_pkg::*;

  localparam int unsigned SUM_W = COORD_W + 2;

  logic [COORD_W-1:0] limit;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    limit = (size > COORD_W'(CURSOR_MARGIN)) ? size - COORD_W'(CURSOR_MARGIN) : '0;
    sum   = {2'b00, pos} + {{(SUM_W-8){delta[7]}}, delta};
    if (sum[SUM_W-1]) begin
      pos_new = '0;
    end else if (sum[SUM_W-2:0] >= {1'b0, limit}) begin
      pos_new = limit;
    end else begin
      pos_new = sum[COORD_W-1:0];
    end
  end

endmodule

// ===== rtl/core/ps2mt_tracker.sv =====
// packet assembly, cursor state, event choice and result register
module ps2mt_tracker #(
  parameter int unsigned CURSOR_MARGIN = ps2mt_pkg::CURSOR_MARGIN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ps2mt_pkg::screen_cfg_t screen_cfg,
  input  logic                   s1_valid,
  input  ps2mt_pkg::in_item_t    s1_item,
  output logic                   s1_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ps2mt_pkg::out_item_t   out_data
);
  import ps2mt_pkg::*;

  byte_phase_t        phase_r;
  logic [7:0]         head_r;
  logic [7:0]         dx_r;
  logic [COORD_W-1:0] pos_x_r;
  logic [COORD_W-1:0] pos_y_r;
  logic               held_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               produce;
  logic               fire;
  logic [7:0]         dy;
  logic [COORD_W-1:0] pos_x_nxt;
  logic [COORD_W-1:0] pos_y_nxt;
  logic               left;
  event_kind_t        kind;

  assign produce  = s1_valid && s1_item.from_aux && (phase_r == PH_DY);
  assign s1_take  = !produce || !out_valid_r || !out_stall;
  assign fire     = s1_valid && s1_take && s1_item.from_aux;
  assign dy       = 8'(8'd0 - s1_item.data_byte);
  assign left     = head_r[LEFT_BIT];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ps2mt_axis_clamp #(.CURSOR_MARGIN(CURSOR_MARGIN)) u_clamp_x (
    .pos     (pos_x_r),
    .delta   (dx_r),
    .size    (screen_cfg.screen_width),
    .pos_new (pos_x_nxt)
  );

  ps2mt_axis_clamp #(.CURSOR_MARGIN(CURSOR_MARGIN)) u_clamp_y (
    .pos     (pos_y_r),
    .delta   (dy),
    .size    (screen_cfg.screen_height),
    .pos_new (pos_y_nxt)
  );

  always_comb begin
    if (left && !held_r) begin
      kind = EV_PRESS;
    end else if (!left && held_r) begin
      kind = EV_RELEASE;
    end else if (left) begin
      kind = EV_DRAG;
    end else if (pos_x_nxt != pos_x_r || pos_y_nxt != pos_y_r) begin
      kind = EV_HOVER;
    end else begin
      kind = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      head_r      <= '0;
      dx_r        <= '0;
      pos_x_r     <= POS_X_RST;
      pos_y_r     <= POS_Y_RST;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (produce && s1_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        case (phase_r)
          PH_HEAD: begin
            head_r  <= s1_item.data_byte;
            phase_r <= PH_DX;
          end
          PH_DX: begin
            dx_r    <= s1_item.data_byte;
            phase_r <= PH_DY;
          end
          PH_DY: begin
            phase_r <= PH_HEAD;
            pos_x_r <= pos_x_nxt;
            pos_y_r <= pos_y_nxt;
            held_r  <= left;
          end
          default: begin
            phase_r <= PH_HEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce && s1_take) begin
      out_data_r.cursor_x   <= pos_x_nxt;
      out_data_r.cursor_y   <= pos_y_nxt;
      out_data_r.prev_x     <= pos_x_r;
      out_data_r.prev_y     <= pos_y_r;
      out_data_r.event_kind <= kind;
      out_data_r.left_down  <= left;
    end
  end

endmodule

// ===== rtl/core/ps2_mouse_packet_cursor_tracker_unit.sv =====
// PS/2 mouse cursor tracker: takes one controller byte request per cycle while
// in_stall is low and gives one cursor request per completed three-byte mouse
// packet. Bytes not flagged as mouse data are dropped. A byte is captured in the
// input register, and the packet result is computed from it combinationally and
// captured in the output register, where out_valid rises. The rate is one
// byte per cycle while in_stall is low, set by the single add-and-clamp pass
// per axis. Stall on the result side holds the result register and stalls the
// input only when a third packet byte is waiting behind an untaken result.
// screen_width and screen_height are written through the cfg port, which is
// always ready, and take effect from the next completed packet.
module ps2_mouse_packet_cursor_tracker_unit #(
  parameter int unsigned CURSOR_MARGIN = ps2mt_pkg::CURSOR_MARGIN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ps2mt_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ps2mt_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2mt_pkg::COORD_W-1:0]       cfg_data
);
  import ps2mt_pkg::*;

  screen_cfg_t screen_cfg_r;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s1_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_cfg_r.screen_width  <= WIDTH_RST;
      screen_cfg_r.screen_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_cfg_r.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_cfg_r.screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ps2mt_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  ps2mt_tracker #(.CURSOR_MARGIN(CURSOR_MARGIN)) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .screen_cfg (screen_cfg_r),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .s1_take    (s1_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/ps2mt_checker.sv =====
// port-level checks for the cursor tracker and their bind
module ps2mt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input ps2mt_pkg::out_item_t out_data
);
  import ps2mt_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_press_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_PRESS || out_data.event_kind == EV_DRAG)
      |-> out_data.left_down)
    else $error("press or drag without left button");

  a_release_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_RELEASE || out_data.event_kind == EV_HOVER ||
                  out_data.event_kind == EV_NONE)
      |-> !out_data.left_down)
    else $error("release or move with left button down");

  a_none_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_NONE
      |-> out_data.cursor_x == out_data.prev_x && out_data.cursor_y == out_data.prev_y)
    else $error("no-change event with moved cursor");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mt_checker u_ps2mt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
